### rtl/core/hfe_pkg.sv
// ----------------------------------------------------------------------------
// hfe_pkg: shared types, codes and constant tables
// Command/status structs between controller and datapath, micro-op codes,
// the CORDIC arctangent table and the CORDIC gain function.
// ----------------------------------------------------------------------------
`default_nettype none

package hfe_pkg;

  // input op codes
  localparam logic [2:0] OP_ROOT   = 3'd0;
  localparam logic [2:0] OP_JPOS   = 3'd1;
  localparam logic [2:0] OP_JQUAT  = 3'd2;
  localparam logic [2:0] OP_VEC    = 3'd3;
  localparam logic [2:0] OP_OFFSET = 3'd4;

  localparam int ITER_W = 5;

  // fixed-point constants
  localparam logic signed [63:0] HD_ONE54 = 64'sd1 <<< 54;
  localparam logic signed [31:0] TRIG_ONE = 32'sd1 <<< 30;

  // series selectors for the arctangent builder
  localparam int unsigned AT_POW2 = 0;
  localparam int unsigned AT_FIVE = 1;
  localparam int unsigned AT_239  = 2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_HSET, ST_VEC, ST_RINIT,
    ST_ROT, ST_TCS, ST_NEXT, ST_M1, ST_M2, ST_M3, ST_WR, ST_LATCH
  } state_t;

  typedef enum logic [2:0] {
    A_C, A_S, A_PX, A_PZ, A_QW, A_QX, A_QY, A_QZ
  } a_sel_t;

  typedef enum logic [2:0] {
    B_Q0, B_Q1, B_Q2, B_Q3, B_T2, B_T3, B_C, B_S
  } b_sel_t;

  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;

  typedef enum logic [3:0] {
    HD_NONE, HD_NUM_LOAD, HD_NUM_ADD, HD_DEN_LOAD, HD_DEN_ADD, HD_SETUP,
    HD_VEC_STEP, HD_ROT_INIT, HD_ROT_STEP, HD_TRIG_CS
  } hd_op_t;

  typedef enum logic [2:0] {
    PR_R0, PR_R1, PR_R2, PR_R3, PR_VA, PR_VB, PR_T2, PR_T3
  } pair_t;

  typedef enum logic [1:0] {PS_NONE, PS_FRAME, PS_REF} psub_t;
  typedef enum logic [1:0] {TW_NONE, TW_T2, TW_T3} trig_wr_t;
  typedef enum logic {OS_ACC, OS_PY} out_src_t;

  typedef struct packed {
    logic              load_item;
    psub_t             psub;
    logic              root_wr;
    logic              mul_en;
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    acc_op_t           acc_op;
    logic              use_ref;
    hd_op_t            hd_op;
    logic [ITER_W-1:0] iter;
    trig_wr_t          trig_wr;
    logic              ref_latch;
    logic              out_load;
    out_src_t          out_src;
    logic [2:0]        out_slot;
    logic              out_last;
    logic              out_fd;
  } cmd_t;

  typedef struct packed {
    logic deg;
    logic out_free;
  } sts_t;

  typedef struct packed {
    a_sel_t a;
    b_sel_t b;
    logic   sub;
  } mul_ops_t;

  typedef struct packed {
    logic  direct;
    pair_t pair;
  } step_t;

  typedef logic signed [63:0] atan_arr_t [32];

  // operands of the two products that make one result
  function automatic mul_ops_t pair_ops(input pair_t p, input logic second);
    mul_ops_t r;
    r.sub = 1'b0;
    r.a   = A_C;
    r.b   = B_Q0;
    case (p)
      PR_R0: begin r.a = second ? A_S : A_C; r.b = second ? B_Q2 : B_Q0; end
      PR_R1: begin r.a = second ? A_S : A_C; r.b = second ? B_Q3 : B_Q1; r.sub = 1'b1; end
      PR_R2: begin r.a = second ? A_S : A_C; r.b = second ? B_Q0 : B_Q2; r.sub = 1'b1; end
      PR_R3: begin r.a = second ? A_S : A_C; r.b = second ? B_Q1 : B_Q3; end
      PR_VA: begin r.a = second ? A_PZ : A_PX; r.b = second ? B_T3 : B_T2; r.sub = 1'b1; end
      PR_VB: begin r.a = second ? A_PZ : A_PX; r.b = second ? B_T2 : B_T3; end
      PR_T2: begin r.a = second ? A_S : A_C; r.b = second ? B_S : B_C; r.sub = 1'b1; end
      default: begin r.a = A_C; r.b = B_S; end
    endcase
    return r;
  endfunction

  // result program of each op
  function automatic step_t prog(input logic [2:0] op, input logic [2:0] slot);
    step_t r;
    r.direct = 1'b0;
    r.pair   = PR_R0;
    case (op)
      OP_ROOT: begin
        case (slot)
          3'd0:    r.direct = 1'b1;
          3'd1:    r.pair = PR_R0;
          3'd2:    r.pair = PR_R1;
          3'd3:    r.pair = PR_R2;
          default: r.pair = PR_R3;
        endcase
      end
      OP_JPOS, OP_VEC: begin
        case (slot)
          3'd0:    r.pair = PR_VA;
          3'd1:    r.direct = 1'b1;
          default: r.pair = PR_VB;
        endcase
      end
      OP_JQUAT: begin
        case (slot)
          3'd0:    r.pair = PR_R0;
          3'd1:    r.pair = PR_R1;
          3'd2:    r.pair = PR_R2;
          default: r.pair = PR_R3;
        endcase
      end
      default: begin
        case (slot)
          3'd0:    r.pair = PR_VA;
          3'd1:    r.pair = PR_VB;
          3'd2:    r.direct = 1'b1;
          3'd3:    r.pair = PR_R0;
          3'd4:    r.pair = PR_R1;
          3'd5:    r.pair = PR_R2;
          default: r.pair = PR_R3;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [2:0] run_len(input logic [2:0] op);
    logic [2:0] n;
    case (op)
      OP_ROOT:   n = 3'd5;
      OP_JPOS:   n = 3'd3;
      OP_JQUAT:  n = 3'd4;
      OP_VEC:    n = 3'd3;
      OP_OFFSET: n = 3'd7;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  // unsigned quotient by shift and subtract, for elaboration-time tables only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] qt;
    logic [64:0] rem;
    qt  = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem   = rem - {1'b0, d};
        qt[i] = 1'b1;
      end
    end
    return qt;
  endfunction

  // atan(1/n) in Q.60 by its alternating series, each term truncated
  function automatic logic [63:0] atan_inv(input int unsigned sh, input int unsigned mode);
    logic [63:0] pw;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] t;
    logic [63:0] k;
    pos = '0;
    neg = '0;
    k   = '0;
    case (mode)
      AT_FIVE: pw = udiv64(64'd1 << 60, 64'd5);
      AT_239:  pw = udiv64(64'd1 << 60, 64'd239);
      default: pw = (64'd1 << 60) >> sh;
    endcase
    while (pw != 64'd0) begin
      t = udiv64(pw, 64'd2 * k + 64'd1);
      if (k[0]) neg = neg + t;
      else pos = pos + t;
      case (mode)
        AT_FIVE: pw = udiv64(pw, 64'd25);
        AT_239:  pw = udiv64(pw, 64'd57121);
        default: pw = pw >> (2 * sh);
      endcase
      k = k + 64'd1;
    end
    return pos - neg;
  endfunction

  function automatic atan_arr_t build_atan();
    atan_arr_t r;
    r[0] = $signed(64'd4 * atan_inv(0, AT_FIVE) - atan_inv(0, AT_239));
    for (int i = 1; i < 32; i++) r[i] = $signed(atan_inv(i, AT_POW2));
    return r;
  endfunction

  localparam atan_arr_t ATAN_TAB = build_atan();
  localparam logic signed [63:0] PI_Q60 = ATAN_TAB[0] <<< 2;

  // CORDIC gain 1/K in Q.31 for the given step count
  function automatic logic [63:0] cordic_gain(input int unsigned steps);
    logic [63:0] k2;
    logic [63:0] r;
    logic [63:0] b;
    k2 = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (i < steps) k2 = k2 - udiv64(k2, (64'd1 << (2 * i)) + 64'd1);
    end
    r = '0;
    b = 64'd1 << 62;
    while (b > k2) b = b >> 2;
    while (b != 64'd0) begin
      if (k2 >= r + b) begin
        k2 = k2 - (r + b);
        r  = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/hfe_ctrl.sv
// ----------------------------------------------------------------------------
// hfe_ctrl: sequencing controller
// Accepts items, runs the heading CORDIC and the multiply/accumulate steps,
// keeps the frame counter and the joint count register.
// ----------------------------------------------------------------------------
`default_nettype none

module hfe_ctrl #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [2:0]    in_op,
  input  wire logic          in_mk,
  input  wire logic          cfg_we,
  input  wire logic [5:0]    cfg_wdata,
  input  wire hfe_pkg::sts_t sts,
  output hfe_pkg::cmd_t      cmd
);

  localparam logic [hfe_pkg::ITER_W-1:0] ITER_LAST = hfe_pkg::ITER_W'(CORDIC_STEPS - 1);

  hfe_pkg::state_t state, state_next;
  logic [2:0]      op_r, op_r_next;
  logic            mk_r, mk_r_next;
  logic [2:0]      slot, slot_next;
  logic [2:0]      nres, nres_next;
  hfe_pkg::pair_t  pair_r, pair_r_next;
  logic            hd, hd_next;
  logic [hfe_pkg::ITER_W-1:0] iter, iter_next;
  logic            fd_pend, fd_pend_next;
  logic [6:0]      vcount, vcount_next;
  logic [5:0]      joint_count;
  logic [6:0]      vc_inc;

  hfe_pkg::step_t    step;
  hfe_pkg::mul_ops_t ops1, ops2;
  logic              is_last;

  assign step    = hfe_pkg::prog(op_r, slot);
  assign ops1    = hfe_pkg::pair_ops(pair_r, 1'b0);
  assign ops2    = hfe_pkg::pair_ops(pair_r, 1'b1);
  assign is_last = (slot == nres - 3'd1);
  assign vc_inc  = vcount + 7'd1;

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= hfe_pkg::ST_IDLE;
      op_r        <= hfe_pkg::OP_ROOT;
      mk_r        <= 1'b0;
      slot        <= '0;
      nres        <= '0;
      pair_r      <= hfe_pkg::PR_R0;
      hd          <= 1'b0;
      iter        <= '0;
      fd_pend     <= 1'b0;
      vcount      <= '0;
      joint_count <= '0;
    end else begin
      state   <= state_next;
      op_r    <= op_r_next;
      mk_r    <= mk_r_next;
      slot    <= slot_next;
      nres    <= nres_next;
      pair_r  <= pair_r_next;
      hd      <= hd_next;
      iter    <= iter_next;
      fd_pend <= fd_pend_next;
      vcount  <= vcount_next;
      if (cfg_we) joint_count <= cfg_wdata;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    op_r_next    = op_r;
    mk_r_next    = mk_r;
    slot_next    = slot;
    nres_next    = nres;
    pair_r_next  = pair_r;
    hd_next      = hd;
    iter_next    = iter;
    fd_pend_next = fd_pend;
    vcount_next  = vcount;
    s_tready     = 1'b0;
    cmd          = '0;
    cmd.use_ref  = (op_r == hfe_pkg::OP_OFFSET);
    cmd.iter     = iter;
    cmd.out_slot = slot;
    cmd.out_last = is_last;
    cmd.out_fd   = fd_pend & is_last;
    cmd.out_src  = step.direct ? hfe_pkg::OS_PY : hfe_pkg::OS_ACC;

    unique case (state)
      hfe_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          op_r_next     = in_op;
          mk_r_next     = in_mk;
          slot_next     = '0;
          nres_next     = hfe_pkg::run_len(in_op);
          fd_pend_next  = 1'b0;
          hd_next       = 1'b0;
          case (in_op)
            hfe_pkg::OP_ROOT: begin
              cmd.root_wr = 1'b1;
              vcount_next = '0;
              state_next  = hfe_pkg::ST_H1;
            end
            hfe_pkg::OP_JPOS, hfe_pkg::OP_JQUAT: begin
              cmd.psub   = hfe_pkg::PS_FRAME;
              state_next = hfe_pkg::ST_NEXT;
            end
            hfe_pkg::OP_VEC: begin
              // frame counter wraps mod 128 until it hits joint_count + 2
              if (vc_inc == 7'({1'b0, joint_count}) + 7'd2) begin
                fd_pend_next = 1'b1;
                vcount_next  = '0;
              end else begin
                vcount_next = vc_inc;
              end
              state_next = hfe_pkg::ST_NEXT;
            end
            hfe_pkg::OP_OFFSET: begin
              cmd.psub   = hfe_pkg::PS_REF;
              state_next = hfe_pkg::ST_NEXT;
            end
            default: state_next = hfe_pkg::ST_IDLE;
          endcase
        end
      end
      // heading operands: w*y, x*z, y*y, z*z
      hfe_pkg::ST_H1: begin
        cmd.mul_en = 1'b1;
        cmd.a_sel  = hfe_pkg::A_QW;
        cmd.b_sel  = hfe_pkg::B_Q2;
        state_next = hfe_pkg::ST_H2;
      end
      hfe_pkg::ST_H2: begin
        cmd.mul_en = 1'b1;
        cmd.a_sel  = hfe_pkg::A_QX;
        cmd.b_sel  = hfe_pkg::B_Q3;
        cmd.hd_op  = hfe_pkg::HD_NUM_LOAD;
        state_next = hfe_pkg::ST_H3;
      end
      hfe_pkg::ST_H3: begin
        cmd.mul_en = 1'b1;
        cmd.a_sel  = hfe_pkg::A_QY;
        cmd.b_sel  = hfe_pkg::B_Q2;
        cmd.hd_op  = hfe_pkg::HD_NUM_ADD;
        state_next = hfe_pkg::ST_H4;
      end
      hfe_pkg::ST_H4: begin
        cmd.mul_en = 1'b1;
        cmd.a_sel  = hfe_pkg::A_QZ;
        cmd.b_sel  = hfe_pkg::B_Q3;
        cmd.hd_op  = hfe_pkg::HD_DEN_LOAD;
        state_next = hfe_pkg::ST_H5;
      end
      hfe_pkg::ST_H5: begin
        cmd.hd_op  = hfe_pkg::HD_DEN_ADD;
        state_next = hfe_pkg::ST_HSET;
      end
      hfe_pkg::ST_HSET: begin
        cmd.hd_op  = hfe_pkg::HD_SETUP;
        iter_next  = '0;
        state_next = sts.deg ? hfe_pkg::ST_RINIT : hfe_pkg::ST_VEC;
      end
      hfe_pkg::ST_VEC: begin
        cmd.hd_op = hfe_pkg::HD_VEC_STEP;
        if (iter == ITER_LAST) state_next = hfe_pkg::ST_RINIT;
        else iter_next = iter + 1'b1;
      end
      hfe_pkg::ST_RINIT: begin
        cmd.hd_op  = hfe_pkg::HD_ROT_INIT;
        iter_next  = '0;
        state_next = hfe_pkg::ST_ROT;
      end
      hfe_pkg::ST_ROT: begin
        cmd.hd_op = hfe_pkg::HD_ROT_STEP;
        if (iter == ITER_LAST) state_next = hfe_pkg::ST_TCS;
        else iter_next = iter + 1'b1;
      end
      hfe_pkg::ST_TCS: begin
        cmd.hd_op   = hfe_pkg::HD_TRIG_CS;
        hd_next     = 1'b1;
        pair_r_next = hfe_pkg::PR_T2;
        state_next  = hfe_pkg::ST_M1;
      end
      // pick the next result of the run
      hfe_pkg::ST_NEXT: begin
        if (step.direct) begin
          state_next = hfe_pkg::ST_WR;
        end else begin
          pair_r_next = step.pair;
          state_next  = hfe_pkg::ST_M1;
        end
      end
      hfe_pkg::ST_M1: begin
        cmd.mul_en = 1'b1;
        cmd.a_sel  = ops1.a;
        cmd.b_sel  = ops1.b;
        state_next = hfe_pkg::ST_M2;
      end
      hfe_pkg::ST_M2: begin
        cmd.mul_en = 1'b1;
        cmd.a_sel  = ops2.a;
        cmd.b_sel  = ops2.b;
        cmd.acc_op = hfe_pkg::ACC_LOAD;
        state_next = hfe_pkg::ST_M3;
      end
      hfe_pkg::ST_M3: begin
        cmd.acc_op = ops2.sub ? hfe_pkg::ACC_SUB : hfe_pkg::ACC_ADD;
        state_next = hfe_pkg::ST_WR;
      end
      hfe_pkg::ST_WR: begin
        if (hd) begin
          // double-angle terms go to the frame heading
          if (pair_r == hfe_pkg::PR_T2) begin
            cmd.trig_wr = hfe_pkg::TW_T2;
            pair_r_next = hfe_pkg::PR_T3;
            state_next  = hfe_pkg::ST_M1;
          end else begin
            cmd.trig_wr = hfe_pkg::TW_T3;
            hd_next     = 1'b0;
            slot_next   = '0;
            state_next  = mk_r ? hfe_pkg::ST_LATCH : hfe_pkg::ST_NEXT;
          end
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (is_last) begin
            state_next = hfe_pkg::ST_IDLE;
          end else begin
            slot_next  = slot + 3'd1;
            state_next = hfe_pkg::ST_NEXT;
          end
        end
      end
      hfe_pkg::ST_LATCH: begin
        cmd.ref_latch = 1'b1;
        state_next    = hfe_pkg::ST_NEXT;
      end
      default: state_next = hfe_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/hfe_dpath.sv
// ----------------------------------------------------------------------------
// hfe_dpath: arithmetic datapath
// Item registers, root/heading state, shared multiplier and accumulator,
// CORDIC registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hfe_dpath #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [223:0]   in_data,
  input  wire hfe_pkg::cmd_t  cmd,
  output hfe_pkg::sts_t       sts,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic signed [31:0]  out_value,
  output logic [2:0]          out_slot,
  output logic                out_last,
  output logic                out_fd
);

  localparam logic signed [63:0] ROT_X0 =
    $signed(hfe_pkg::cordic_gain(CORDIC_STEPS) << 9);

  // saturate a rounded value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) r = 32'sh7fffffff;
    else if (v < -37'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] clamp1(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(hfe_pkg::TRIG_ONE)) r = hfe_pkg::TRIG_ONE;
    else if (v < -64'(hfe_pkg::TRIG_ONE)) r = -hfe_pkg::TRIG_ONE;
    else r = v[31:0];
    return r;
  endfunction

  logic signed [31:0] in_v [3];
  logic signed [31:0] in_q [4];
  logic signed [31:0] q [4];
  logic signed [32:0] px, py, pz;
  logic signed [31:0] froot [3];
  logic signed [31:0] rroot [3];
  logic signed [31:0] ft [4];
  logic signed [31:0] rt [4];
  logic signed [31:0] base [3];
  logic signed [31:0] tc, ts, t2, t3;

  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] prod;
  logic signed [66:0] acc;
  logic signed [66:0] rsum;
  logic signed [31:0] acc_rnd;
  logic signed [31:0] py_sat;

  logic signed [63:0] nsum, dsum, cx, cy, ang;
  logic signed [63:0] num_s, den_s, prod_s6;
  logic signed [63:0] sh_x, sh_y, at_i;

  // unpack the item
  always_comb begin
    for (int i = 0; i < 3; i++) in_v[i] = in_data[32*i +: 32];
    for (int i = 0; i < 4; i++) in_q[i] = in_data[96 + 32*i +: 32];
    for (int i = 0; i < 3; i++) begin
      case (cmd.psub)
        hfe_pkg::PS_FRAME: base[i] = froot[i];
        hfe_pkg::PS_REF:   base[i] = rroot[i];
        default:           base[i] = '0;
      endcase
    end
  end

  // active heading
  assign tc = cmd.use_ref ? rt[0] : ft[0];
  assign ts = cmd.use_ref ? rt[1] : ft[1];
  assign t2 = cmd.use_ref ? rt[2] : ft[2];
  assign t3 = cmd.use_ref ? rt[3] : ft[3];

  // multiplier operand selection
  always_comb begin
    case (cmd.a_sel)
      hfe_pkg::A_C:  mul_a = 33'(tc);
      hfe_pkg::A_S:  mul_a = 33'(ts);
      hfe_pkg::A_PX: mul_a = px;
      hfe_pkg::A_PZ: mul_a = pz;
      hfe_pkg::A_QW: mul_a = 33'(q[0]);
      hfe_pkg::A_QX: mul_a = 33'(q[1]);
      hfe_pkg::A_QY: mul_a = 33'(q[2]);
      default:       mul_a = 33'(q[3]);
    endcase
    case (cmd.b_sel)
      hfe_pkg::B_Q0: mul_b = q[0];
      hfe_pkg::B_Q1: mul_b = q[1];
      hfe_pkg::B_Q2: mul_b = q[2];
      hfe_pkg::B_Q3: mul_b = q[3];
      hfe_pkg::B_T2: mul_b = t2;
      hfe_pkg::B_T3: mul_b = t3;
      hfe_pkg::B_C:  mul_b = tc;
      default:       mul_b = ts;
    endcase
  end

  // round half up at bit 30, then saturate
  assign rsum    = acc + 67'sd536870912;
  assign acc_rnd = sat32(37'(rsum >>> 30));
  assign py_sat  = sat32(37'(py));

  // heading setup terms
  assign prod_s6 = 64'(prod >>> 6);
  assign num_s   = nsum <<< 1;
  assign den_s   = hfe_pkg::HD_ONE54 - (dsum <<< 1);
  assign sh_x    = cx >>> cmd.iter;
  assign sh_y    = cy >>> cmd.iter;
  assign at_i    = hfe_pkg::ATAN_TAB[cmd.iter];

  assign sts.deg      = (num_s == 64'sd0) && (den_s == 64'sd0);
  assign sts.out_free = !m_tvalid || m_tready;

  // item registers and multiply/accumulate
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      for (int i = 0; i < 4; i++) q[i] <= in_q[i];
      px <= 33'(in_v[0]) - 33'(base[0]);
      py <= 33'(in_v[1]) - 33'(base[1]);
      pz <= 33'(in_v[2]) - 33'(base[2]);
    end
    if (cmd.mul_en) prod <= mul_a * mul_b;
    case (cmd.acc_op)
      hfe_pkg::ACC_LOAD: acc <= 67'(prod);
      hfe_pkg::ACC_ADD:  acc <= acc + 67'(prod);
      hfe_pkg::ACC_SUB:  acc <= acc - 67'(prod);
      default:           acc <= acc;
    endcase
  end

  // heading CORDIC: vectoring for yaw, rotation for half-angle trig
  always_ff @(posedge clk) begin
    case (cmd.hd_op)
      hfe_pkg::HD_NUM_LOAD: nsum <= prod_s6;
      hfe_pkg::HD_NUM_ADD:  nsum <= nsum + prod_s6;
      hfe_pkg::HD_DEN_LOAD: dsum <= prod_s6;
      hfe_pkg::HD_DEN_ADD:  dsum <= dsum + prod_s6;
      hfe_pkg::HD_SETUP: begin
        if (den_s < 0) begin
          ang <= (num_s >= 0) ? hfe_pkg::PI_Q60 : -hfe_pkg::PI_Q60;
          cx  <= -den_s;
          cy  <= -num_s;
        end else begin
          ang <= '0;
          cx  <= den_s;
          cy  <= num_s;
        end
      end
      hfe_pkg::HD_VEC_STEP: begin
        if (cy >= 0) begin
          cx  <= cx + sh_y;
          cy  <= cy - sh_x;
          ang <= ang + at_i;
        end else begin
          cx  <= cx - sh_y;
          cy  <= cy + sh_x;
          ang <= ang - at_i;
        end
      end
      hfe_pkg::HD_ROT_INIT: begin
        ang <= ang >>> 1;
        cx  <= ROT_X0;
        cy  <= '0;
      end
      hfe_pkg::HD_ROT_STEP: begin
        if (ang >= 0) begin
          cx  <= cx - sh_y;
          cy  <= cy + sh_x;
          ang <= ang - at_i;
        end else begin
          cx  <= cx + sh_y;
          cy  <= cy - sh_x;
          ang <= ang + at_i;
        end
      end
      default: ;
    endcase
  end

  // root and heading state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        froot[i] <= '0;
        rroot[i] <= '0;
      end
      ft[0] <= hfe_pkg::TRIG_ONE;
      ft[1] <= '0;
      ft[2] <= hfe_pkg::TRIG_ONE;
      ft[3] <= '0;
      rt[0] <= hfe_pkg::TRIG_ONE;
      rt[1] <= '0;
      rt[2] <= hfe_pkg::TRIG_ONE;
      rt[3] <= '0;
    end else begin
      if (cmd.root_wr) begin
        for (int i = 0; i < 3; i++) froot[i] <= in_v[i];
      end
      if (cmd.hd_op == hfe_pkg::HD_TRIG_CS) begin
        ft[0] <= clamp1((cx + 64'sd512) >>> 10);
        ft[1] <= clamp1((cy + 64'sd512) >>> 10);
      end
      case (cmd.trig_wr)
        hfe_pkg::TW_T2: ft[2] <= clamp1(64'(acc_rnd));
        hfe_pkg::TW_T3: ft[3] <= clamp1(64'(acc_rnd));
        default: ;
      endcase
      if (cmd.ref_latch) begin
        for (int i = 0; i < 3; i++) rroot[i] <= froot[i];
        for (int i = 0; i < 4; i++) rt[i] <= ft[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value <= (cmd.out_src == hfe_pkg::OS_PY) ? py_sat : acc_rnd;
      out_slot  <= cmd.out_slot;
      out_last  <= cmd.out_last;
      out_fd    <= cmd.out_fd;
    end
  end

endmodule

`default_nettype wire

### rtl/core/heading_frame_pose_encoder_unit.sv
// ----------------------------------------------------------------------------
// heading_frame_pose_encoder_unit: pose features in the root heading frame
// Top level: controller plus datapath with stream ports and one register.
// ----------------------------------------------------------------------------
// One item is taken at a time. A product-pair result runs its two products
// through one shared 33x32 multiplier, then accumulates and rounds; a
// pass-through result goes straight to the output register. A root item
// also runs the heading setup, two CORDIC passes of CORDIC_STEPS steps
// each and the double-angle work. A stalled output holds the unit until
// the output register is free. Results leave through an output register,
// so the input side opens again as soon as the last result is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module heading_frame_pose_encoder_unit #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // configuration: joint_count
  input  wire logic         cfg_we,
  input  wire logic [5:0]   cfg_wdata,
  // request in
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [223:0] s_tdata,  // vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z
  input  wire logic [3:0]   s_tuser,  // op[2:0], make_reference[3]
  // results out
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [39:0]       m_tdata,  // value[31:0], slot[34:32], zero fill
  output logic              m_tlast,
  output logic [0:0]        m_tuser   // frame_done
);

  hfe_pkg::cmd_t      cmd;
  hfe_pkg::sts_t      sts;
  logic signed [31:0] out_value;
  logic [2:0]         out_slot;
  logic               out_fd;

  hfe_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .in_op    (s_tuser[2:0]),
    .in_mk    (s_tuser[3]),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .sts      (sts),
    .cmd      (cmd)
  );

  hfe_dpath #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .out_value(out_value),
    .out_slot (out_slot),
    .out_last (m_tlast),
    .out_fd   (out_fd)
  );

  assign m_tdata = {5'b0, out_slot, out_value};
  assign m_tuser = out_fd;

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stream testbench for heading_frame_pose_encoder_unit
// Drives root, joint, quaternion, vector and offset requests with random
// bursts and gaps, stalls the result side on its own pattern, and checks
// every result field against an in-bench fixed-point heading-frame model.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STEPS     = 24;
  localparam int LIMIT     = 600000;
  localparam int SETTLE    = 150;
  localparam longint ONE30 = 64'sd1 <<< 30;

  typedef struct {
    logic signed [31:0] value;
    logic [2:0]         slot;
    logic               last;
    logic               fd;
  } feature_t;

  typedef logic signed [31:0] word_t;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [5:0]   cfg_wdata;
  logic         s_tvalid;
  logic         s_tready;
  logic [223:0] s_tdata;   // vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z
  logic [3:0]   s_tuser;   // op[2:0], make_reference[3]
  logic         m_tvalid;
  logic         m_tready;
  logic [39:0]  m_tdata;   // value[31:0], slot[34:32], zero fill
  logic         m_tlast;
  logic [0:0]   m_tuser;   // frame_done

  heading_frame_pose_encoder_unit #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  // clock
  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // model state
  longint      atan_q60 [32];
  longint      gain_q31;
  logic [5:0]  joints;
  longint      root_pos [3];
  longint      root_trig [4];
  longint      ref_pos [3];
  longint      ref_trig [4];
  logic [6:0]  vec_count;

  feature_t    pending [$];
  int          errors;
  int          cycles;

  // sender pacing and receiver stall controls
  int          burst_left;
  bit          no_gaps;
  int          rx_mode;
  int          hold_req;
  int          hold_cnt;
  int          rx_phase;

  // ---------------------------------------------------------------- tables
  // atan(1/n) in Q.60 by its alternating series
  function automatic longint unsigned atan_series(input longint unsigned n);
    longint unsigned pw, nn, pos, neg, k;
    pw  = (64'd1 << 60) / n;
    nn  = n * n;
    pos = 0;
    neg = 0;
    k   = 0;
    while (pw != 0) begin
      if (k[0]) neg += pw / (2 * k + 1);
      else pos += pw / (2 * k + 1);
      pw = pw / nn;
      k++;
    end
    return pos - neg;
  endfunction

  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic init_tables();
    longint unsigned k2;
    atan_q60[0] = longint'(4 * atan_series(5) - atan_series(239));
    for (int i = 1; i < 32; i++) atan_q60[i] = longint'(atan_series(64'd1 << i));
    k2 = 64'd1 << 62;
    for (int i = 0; i < STEPS; i++) k2 -= k2 / ((64'd1 << (2 * i)) + 1);
    gain_q31 = longint'(root64(k2));
  endtask

  // ------------------------------------------------------------ arithmetic
  function automatic longint sat_word(input logic signed [95:0] v);
    if (v > 96'sd2147483647) return 2147483647;
    if (v < -96'sd2147483648) return -2147483648;
    return longint'(v);
  endfunction

  function automatic longint round_q30(input logic signed [95:0] v);
    return sat_word((v + (96'sd1 <<< 29)) >>> 30);
  endfunction

  function automatic longint clamp_unit(input longint v);
    if (v > ONE30) return ONE30;
    if (v < -ONE30) return -ONE30;
    return v;
  endfunction

  // heading trig {cos half, sin half, cos yaw, sin yaw} from a rotation
  task automatic yaw_trig(input longint w, x, y, z, output longint t [4]);
    longint num, den, ang, cx, cy, dx, dy, c, s;
    num = 2 * (((w * y) >>> 6) + ((x * z) >>> 6));
    den = (64'sd1 <<< 54) - 2 * (((y * y) >>> 6) + ((z * z) >>> 6));
    ang = 0;
    if (num != 0 || den != 0) begin
      if (den < 0) begin
        ang = (num >= 0) ? 4 * atan_q60[0] : -4 * atan_q60[0];
        den = -den;
        num = -num;
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = num >>> i;
        dy = den >>> i;
        if (num >= 0) begin
          den += dx; num -= dy; ang += atan_q60[i];
        end else begin
          den -= dx; num += dy; ang -= atan_q60[i];
        end
      end
    end
    ang = ang >>> 1;
    cx  = gain_q31 * 512;
    cy  = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = cx >>> i;
      dy = cy >>> i;
      if (ang >= 0) begin
        cx -= dy; cy += dx; ang -= atan_q60[i];
      end else begin
        cx += dy; cy -= dx; ang += atan_q60[i];
      end
    end
    c = clamp_unit((cx + 512) >>> 10);
    s = clamp_unit((cy + 512) >>> 10);
    t[0] = c;
    t[1] = s;
    t[2] = clamp_unit(round_q30(c * c - s * s));
    t[3] = clamp_unit(round_q30(2 * c * s));
  endtask

  // inverse heading times quaternion
  task automatic unyaw_quat(input longint t [4], input longint q [4], output longint r [4]);
    r[0] = round_q30(t[0] * q[0] + t[1] * q[2]);
    r[1] = round_q30(t[0] * q[1] - t[1] * q[3]);
    r[2] = round_q30(t[0] * q[2] - t[1] * q[0]);
    r[3] = round_q30(t[0] * q[3] + t[1] * q[1]);
  endtask

  task automatic unyaw_xz(input longint t [4], input longint x, z, output longint rx, rz);
    logic signed [95:0] xw, zw;
    xw = x;
    zw = z;
    rx = round_q30(xw * t[2] - zw * t[3]);
    rz = round_q30(xw * t[3] + zw * t[2]);
  endtask

  task automatic push_feature(input longint v, input int k, input int n, input logic fd);
    feature_t f;
    f.value = v[31:0];
    f.slot  = k[2:0];
    f.last  = (k == n - 1);
    f.fd    = fd;
    pending.push_back(f);
  endtask

  // expected features of one accepted request
  task automatic predict_features(input logic [2:0] op, input logic mk,
                                  input word_t v [3], input word_t qw [4]);
    longint p [3];
    longint q [4];
    longint r [4];
    longint a, b;
    logic   fd;
    for (int i = 0; i < 3; i++) p[i] = v[i];
    for (int i = 0; i < 4; i++) q[i] = qw[i];
    case (op)
      hfe_pkg::OP_ROOT: begin
        yaw_trig(q[0], q[1], q[2], q[3], root_trig);
        root_pos = p;
        if (mk) begin
          ref_pos  = p;
          ref_trig = root_trig;
        end
        vec_count = '0;
        unyaw_quat(root_trig, q, r);
        push_feature(p[1], 0, 5, 1'b0);
        for (int i = 0; i < 4; i++) push_feature(r[i], 1 + i, 5, 1'b0);
      end
      hfe_pkg::OP_JPOS: begin
        unyaw_xz(root_trig, p[0] - root_pos[0], p[2] - root_pos[2], a, b);
        push_feature(a, 0, 3, 1'b0);
        push_feature(sat_word(p[1] - root_pos[1]), 1, 3, 1'b0);
        push_feature(b, 2, 3, 1'b0);
      end
      hfe_pkg::OP_JQUAT: begin
        unyaw_quat(root_trig, q, r);
        for (int i = 0; i < 4; i++) push_feature(r[i], i, 4, 1'b0);
      end
      hfe_pkg::OP_VEC: begin
        vec_count = vec_count + 7'd1;
        fd = (vec_count == {1'b0, joints} + 7'd2);
        if (fd) vec_count = '0;
        unyaw_xz(root_trig, p[0], p[2], a, b);
        push_feature(a, 0, 3, 1'b0);
        push_feature(p[1], 1, 3, 1'b0);
        push_feature(b, 2, 3, fd);
      end
      hfe_pkg::OP_OFFSET: begin
        unyaw_xz(ref_trig, p[0] - ref_pos[0], p[2] - ref_pos[2], a, b);
        unyaw_quat(ref_trig, q, r);
        push_feature(a, 0, 7, 1'b0);
        push_feature(b, 1, 7, 1'b0);
        push_feature(sat_word(p[1] - ref_pos[1]), 2, 7, 1'b0);
        for (int i = 0; i < 4; i++) push_feature(r[i], 3 + i, 7, 1'b0);
      end
      default: ;  // unused codes: no result, no state change
    endcase
  endtask

  // ------------------------------------------------------------ stimulus
  // one request; valid stays high after acceptance unless a gap follows
  task automatic send_request(input logic [2:0] op, input logic mk,
                              input word_t v [3], input word_t q [4]);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {q[3], q[2], q[1], q[0], v[2], v[1], v[0]};
    s_tuser  <= {mk, op};
    forever begin
      @(negedge clk);
      if (s_tready) begin
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
    predict_features(op, mk, v, q);
  endtask

  // send pauses until every expected result is back, then lets the block settle
  task automatic drain();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_joint_count(input logic [5:0] n);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we    <= 1'b0;
    joints = n;
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2, 3, 4: return $signed($urandom_range(0, 32'h0003FFFF)) - 32'sh00020000;
      default: return $urandom;
    endcase
  endfunction

  // quaternion with each part either within half a unit or a raw random word
  task automatic rand_quat(output word_t q [4]);
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(0, 3) == 0) q[i] = rand_word();
      else q[i] = $signed($urandom_range(0, 32'h3FFFFFFF)) - 32'sh20000000;
    end
  endtask

  task automatic send_random(input logic [2:0] op, input logic mk);
    word_t v [3];
    word_t q [4];
    for (int i = 0; i < 3; i++) v[i] = rand_word();
    rand_quat(q);
    send_request(op, mk, v, q);
  endtask

  task automatic send_fixed(input logic [2:0] op, input logic mk,
                            input word_t x, y, z, qw, qx, qy, qz);
    word_t v [3];
    word_t q [4];
    v = '{x, y, z};
    q = '{qw, qx, qy, qz};
    send_request(op, mk, v, q);
  endtask

  // ------------------------------------------------------------ tests
  // reset state: identity heading, zero roots, joint_count of zero
  task automatic test_reset_state();
    send_fixed(hfe_pkg::OP_JPOS, 1'b0, 32'sd65536, -32'sd65536, 32'sd12345, 0, 0, 0, 0);
    send_fixed(hfe_pkg::OP_JQUAT, 1'b1, 0, 0, 0, 32'sh40000000, 32'sd1000, -32'sd2000,
               32'sd3);
    send_fixed(hfe_pkg::OP_VEC, 1'b0, 32'sd7, 32'sd8, 32'sd9, 0, 0, 0, 0);
    send_fixed(hfe_pkg::OP_VEC, 1'b0, -32'sd7, -32'sd8, -32'sd9, 0, 0, 0, 0);
    send_fixed(hfe_pkg::OP_OFFSET, 1'b0, 32'sd100, 32'sd200, 32'sd300,
               32'sh40000000, 0, 0, 0);
  endtask

  // root corner cases and the op codes with no result
  task automatic test_root_cases();
    // zero quaternion: atan2 numerator zero, denominator positive
    send_fixed(hfe_pkg::OP_ROOT, 1'b0, 1, 2, 3, 0, 0, 0, 0);
    send_fixed(hfe_pkg::OP_JQUAT, 1'b0, 0, 0, 0, 32'sh40000000, 0, 32'sh20000000, 0);
    // denominator exactly zero, numerator zero
    send_fixed(hfe_pkg::OP_ROOT, 1'b0, 0, 0, 0, 0, 0, 32'sh20000000, 32'sh20000000);
    // negative denominator with zero numerator: yaw of pi
    send_fixed(hfe_pkg::OP_ROOT, 1'b1, 32'sd65536, 32'sd131072, -32'sd65536,
               0, 0, 32'sh40000000, 0);
    send_fixed(hfe_pkg::OP_OFFSET, 1'b0, 0, 0, 0, 32'sh40000000, 0, 0, 0);
    // identity: trig values run into the unit clamp
    send_fixed(hfe_pkg::OP_ROOT, 1'b1, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
               32'sh40000000, 0, 0, 0);
    send_fixed(hfe_pkg::OP_JPOS, 1'b0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
               0, 0, 0, 0);
    // extreme quaternion
    send_fixed(hfe_pkg::OP_ROOT, 1'b0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
               32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
    send_fixed(hfe_pkg::OP_JQUAT, 1'b0, 0, 0, 0,
               32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
    send_fixed(hfe_pkg::OP_VEC, 1'b1, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
               0, 0, 0, 0);
    // unused codes are dropped
    send_fixed(3'd5, 1'b1, 1, 1, 1, 1, 1, 1, 1);
    send_fixed(3'd6, 1'b0, 1, 1, 1, 1, 1, 1, 1);
    send_fixed(3'd7, 1'b1, 1, 1, 1, 1, 1, 1, 1);
    send_fixed(hfe_pkg::OP_OFFSET, 1'b1, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
               32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000);
  endtask

  // frame counter: a count below a high target, then a count past a lowered target
  task automatic test_frame_count();
    set_joint_count(6'd63);
    send_random(hfe_pkg::OP_ROOT, 1'b0);
    repeat (10) send_random(hfe_pkg::OP_VEC, 1'b0);
    set_joint_count(6'd0);
    // count 10 now wraps round to a target of two
    repeat (122) send_random(hfe_pkg::OP_VEC, 1'b0);
    set_joint_count(6'd1);
    send_random(hfe_pkg::OP_ROOT, 1'b0);
    repeat (7) send_random(hfe_pkg::OP_VEC, 1'b0);
  endtask

  // receiver holds off long enough that the block stalls its input
  task automatic test_backpressure();
    drain();
    no_gaps  = 1'b1;
    hold_req = 400;
    send_random(hfe_pkg::OP_ROOT, 1'b1);
    repeat (4) send_random(hfe_pkg::OP_OFFSET, 1'b0);
    repeat (4) send_random(hfe_pkg::OP_JPOS, 1'b0);
    no_gaps = 1'b0;
  endtask

  // well-formed frames with random content, plus noise
  task automatic test_random_frames(input int items);
    int sent;
    int k;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 3) == 0) rx_mode = $urandom_range(0, 2);
      no_gaps = ($urandom_range(0, 4) == 0);
      send_random(hfe_pkg::OP_ROOT, $urandom_range(0, 1));
      sent++;
      k = $urandom_range(1, 6);
      repeat (k) begin
        send_random(hfe_pkg::OP_JPOS, $urandom_range(0, 1));
        send_random(hfe_pkg::OP_JQUAT, $urandom_range(0, 1));
        sent += 2;
      end
      repeat (joints + 2) begin
        send_random(hfe_pkg::OP_VEC, $urandom_range(0, 1));
        sent++;
      end
      if ($urandom_range(0, 1)) begin
        send_random(hfe_pkg::OP_OFFSET, $urandom_range(0, 1));
        sent++;
      end
      if ($urandom_range(0, 5) == 0) begin
        send_random($urandom_range(0, 7), $urandom_range(0, 1));
        sent++;
      end
    end
  endtask

  // ------------------------------------------------------------ receiver
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_cnt <= hold_req;
      hold_req = 0;
      m_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      rx_phase <= (rx_phase + 1) % 5;
      case (rx_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= (rx_phase < 2);
      endcase
    end
  end

  // result check, sampled between edges
  always @(negedge clk) begin
    feature_t f;
    if (!rst && m_tvalid && m_tready) begin
      if (pending.size() == 0) begin
        $error("unexpected result value=%0d slot=%0d", $signed(m_tdata[31:0]), m_tdata[34:32]);
        errors++;
      end else begin
        f = pending.pop_front();
        if (m_tdata[31:0] !== f.value) begin
          $error("value: expected %0d, got %0d", f.value, $signed(m_tdata[31:0]));
          errors++;
        end
        if (m_tdata[34:32] !== f.slot) begin
          $error("slot: expected %0d, got %0d", f.slot, m_tdata[34:32]);
          errors++;
        end
        if (m_tlast !== f.last) begin
          $error("last: expected %0d, got %0d", f.last, m_tlast);
          errors++;
        end
        if (m_tuser[0] !== f.fd) begin
          $error("frame_done: expected %0d, got %0d", f.fd, m_tuser[0]);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ------------------------------------------------------------ sequence
  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    m_tready   = 1'b0;
    errors     = 0;
    cycles     = 0;
    burst_left = 0;
    no_gaps    = 1'b0;
    rx_mode    = 1;
    hold_req   = 0;
    hold_cnt   = 0;
    rx_phase   = 0;
    joints     = '0;
    vec_count  = '0;
    root_pos   = '{0, 0, 0};
    ref_pos    = '{0, 0, 0};
    root_trig  = '{ONE30, 0, ONE30, 0};
    ref_trig   = '{ONE30, 0, ONE30, 0};
    init_tables();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_root_cases();
    test_frame_count();
    test_backpressure();
    set_joint_count(6'd2);
    test_random_frames(15);
    set_joint_count(6'($urandom_range(0, 5)));
    rx_mode = 0;
    test_random_frames(12);
    set_joint_count(6'd0);
    test_random_frames(10);

    drain();
    if (errors == 0 && pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/hfe_pkg.sv
rtl/core/hfe_ctrl.sv
rtl/core/hfe_dpath.sv
rtl/core/heading_frame_pose_encoder_unit.sv
tb/sv/tb_top.sv
